[hw/rtl/signed_integer_to_radix_symbols_top_assert.svh]
// Assertion macros for the radix symbol converter.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SIRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define SIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SIRS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/sirs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the symbol lookup for the radix symbol converter.
// No dependencies.
package sirs_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int MAG_W           = 32;
    localparam int CNT_W           = 5;
    localparam int NUM_CELLS       = 32;
    localparam int CELL_IDX_W      = 5;
    localparam int RADIX_W         = 5;
    localparam int ALPHA_W         = 64;
    localparam int SYM_W           = 8;
    localparam int SYM_IDX_W       = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] SYM_PLUS    = 8'd43;
    localparam logic [SYM_W-1:0] SYM_MINUS   = 8'd45;
    localparam logic [SYM_W-1:0] SYM_LOWEST  = 8'd32;
    localparam logic [SYM_W-1:0] SYM_HIGHEST = 8'd127;

    localparam logic [CNT_W-1:0] CNT_LAST = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_WAIT,
        ST_SIGN,
        ST_DIG
    } sirs_state_t;

    // One step of the bit wave that travels along the digit cells.
    typedef struct packed {
        logic vld;
        logic first;
        logic fin;
        logic carry;
    } sirs_link_t;

    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [ALPHA_W-1:0]   lo,
        input logic [ALPHA_W-1:0]   hi,
        input logic [SYM_IDX_W-1:0] d
    );
        logic [ALPHA_W-1:0] word;
        logic [ALPHA_W-1:0] shifted;
        word    = d[3] ? hi : lo;
        shifted = word >> {d[2:0], 3'b000};
        return shifted[SYM_W-1:0];
    endfunction

    function automatic logic sym_legal(input logic [SYM_W-1:0] c);
        return (c != SYM_PLUS) && (c != SYM_MINUS) && (c >= SYM_LOWEST) && (c <= SYM_HIGHEST);
    endfunction

endpackage

[hw/rtl/sirs_cell.sv]
`timescale 1ns / 1ps
// One digit cell: doubles its digit, adds the incoming carry and reduces modulo the radix.
// Depends on sirs_pkg.
module sirs_cell import sirs_pkg::*; #(
    parameter int DIGIT_W = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RADIX_W-1:0] radix,
    input  sirs_link_t         link_in,
    output sirs_link_t         link_out,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    sirs_link_t         link_reg;
    sirs_link_t         link_next;
    logic [DIGIT_W-1:0] base;
    logic [DIGIT_W:0]   dbl;
    logic [RADIX_W-1:0] dbl_ext;
    logic [RADIX_W-1:0] diff;
    logic               ge;

    always_comb
    begin
        base       = link_in.first ? '0 : digit_reg;
        dbl        = {base, link_in.carry};
        dbl_ext    = RADIX_W'(dbl);
        ge         = (dbl_ext >= radix);
        diff       = dbl_ext - radix;
        digit_next = digit_reg;
        link_next  = link_in;
        if (link_in.vld)
        begin
            digit_next = ge ? DIGIT_W'(diff) : DIGIT_W'(dbl_ext);
        end
        link_next.carry = link_in.vld & ge;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign link_out = link_reg;
    assign digit    = digit_reg;

endmodule

[hw/rtl/sirs_alpha_chk.sv]
`timescale 1ns / 1ps
// Registered validity check of the radix and the digit alphabet.
// Depends on sirs_pkg.
module sirs_alpha_chk import sirs_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RADIX_W-1:0] radix_size,
    input  logic [ALPHA_W-1:0] alphabet_low,
    input  logic [ALPHA_W-1:0] alphabet_high,
    output logic               ok
);

    logic [SYM_W-1:0] sym [MAX_SYMBOLS];
    logic             bad;
    logic             ok_reg;
    logic             ok_next;

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym[i] = symbol_of(alphabet_low, alphabet_high, SYM_IDX_W'(i));
        end
    end

    always_comb
    begin
        bad = 1'b0;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (radix_size > RADIX_W'(i))
            begin
                if (!sym_legal(sym[i]))
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if ((radix_size > RADIX_W'(j)) && (sym[i] == sym[j]))
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
        ok_next = (radix_size >= RADIX_W'(2)) && (radix_size <= RADIX_W'(MAX_SYMBOLS)) && !bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
        end
    end

    assign ok = ok_reg;

endmodule

[hw/rtl/signed_integer_to_radix_symbols_top.sv]
`timescale 1ns / 1ps
// A new number is accepted only in the idle state, so conversions do not overlap.
// The 32 magnitude bits enter the digit cell row one per cycle and the bit wave crosses
// its 32 cells; then the symbols leave the output register one per cycle while m_axis_tready
// is held high.
// Reset is asynchronous and active low; it clears control state and the configuration registers to zero.
// Top level; depends on sirs_pkg, sirs_cell, sirs_alpha_chk and the assertion header.
`include "signed_integer_to_radix_symbols_top_assert.svh"

module signed_integer_to_radix_symbols_top import sirs_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic signed [MAG_W-1:0] s_axis_tdata,   // number
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [SYM_W-1:0]     m_axis_tdata,      // symbol
    output logic                 m_axis_tlast
);

    localparam int DIGIT_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

    logic [RADIX_W-1:0]    radix_reg;
    logic [ALPHA_W-1:0]    alo_reg;
    logic [ALPHA_W-1:0]    ahi_reg;
    logic                  ok;

    sirs_state_t           state_reg;
    sirs_state_t           state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [CELL_IDX_W-1:0] idx_reg;
    logic [CELL_IDX_W-1:0] idx_next;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    logic [SYM_W-1:0]      out_sym_reg;
    logic [SYM_W-1:0]      out_sym_next;
    logic                  out_last_reg;
    logic                  out_last_next;

    sirs_link_t            link_head;
    sirs_link_t            link [NUM_CELLS+1];
    logic [DIGIT_W-1:0]    digit [NUM_CELLS];
    logic [CELL_IDX_W-1:0] msd;
    logic                  chain_done;
    logic                  out_free;
    logic [MAG_W-1:0]      raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
            alo_reg   <= '0;
            ahi_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIX_SIZE:    radix_reg <= cfg_data[RADIX_W-1:0];
                REG_ALPHABET_LOW:  alo_reg   <= cfg_data;
                REG_ALPHABET_HIGH: ahi_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    sirs_alpha_chk #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .radix_size   (radix_reg),
        .alphabet_low (alo_reg),
        .alphabet_high(ahi_reg),
        .ok           (ok)
    );

    assign link[0] = link_head;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        sirs_cell #(
            .DIGIT_W(DIGIT_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .radix   (radix_reg),
            .link_in (link[k]),
            .link_out(link[k+1]),
            .digit   (digit[k])
        );
    end

    assign chain_done = link[NUM_CELLS].vld & link[NUM_CELLS].fin;

    always_comb
    begin
        msd = '0;
        for (int k = 0; k < NUM_CELLS; k++)
        begin
            if (digit[k] != '0)
            begin
                msd = CELL_IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        idx_next      = idx_reg;
        out_vld_next  = out_vld_reg;
        out_sym_next  = out_sym_reg;
        out_last_next = out_last_reg;
        link_head     = '0;
        raw           = unsigned'(s_axis_tdata);
        out_free      = !out_vld_reg || m_axis_tready;
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next   = raw[MAG_W-1];
                    mag_next   = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                link_head.vld   = 1'b1;
                link_head.first = (cnt_reg == '0);
                link_head.fin   = (cnt_reg == CNT_LAST);
                link_head.carry = mag_reg[MAG_W-1];
                mag_next        = {mag_reg[MAG_W-2:0], 1'b0};
                cnt_next        = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (chain_done)
                begin
                    idx_next = msd;
                    if (!ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (neg_reg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_DIG;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_sym_next  = SYM_MINUS;
                    out_last_next = 1'b0;
                    state_next    = ST_DIG;
                end
            end
            ST_DIG:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_sym_next  = symbol_of(alo_reg, ahi_reg, SYM_IDX_W'(digit[idx_reg]));
                    out_last_next = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - CELL_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            neg_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            neg_reg     <= neg_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;

    `SIRS_ASSERT_IMPL(a_done_in_wait, clk, rst_n, chain_done, state_reg == ST_WAIT)
    `SIRS_ASSERT_NEXT(a_accept_starts, clk, rst_n,
        s_axis_tvalid && s_axis_tready, state_reg == ST_CONV)
    `SIRS_ASSERT_NEXT(a_last_ends, clk, rst_n,
        (state_reg == ST_DIG) && out_free && (idx_reg == '0), state_reg == ST_IDLE && m_axis_tlast)
    `SIRS_ASSERT_IMPL(a_minus_not_last, clk, rst_n,
        out_vld_reg && (out_sym_reg == SYM_MINUS), !out_last_reg)

endmodule
